// ----- hdl/inode_byte_address_calc_top_defines.svh -----
// Assertion macros for the inode byte address calculator.
// Used by the top level; no other dependencies.
`ifndef INODE_BYTE_ADDRESS_CALC_TOP_DEFINES_SVH
`define INODE_BYTE_ADDRESS_CALC_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define IBAC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define IBAC_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define IBAC_ASSERT(lbl, clk, rst_n, prop, msg)
`define IBAC_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ----- hdl/ibac_pkg.sv -----
// Shared types and constants of the inode byte address calculator.
// No dependencies.
`default_nettype none
package ibac_pkg;
	localparam int WORD_W           = 32;
	localparam int OFS_W            = 63;
	localparam int IDX_W            = 4;
	localparam int BLK_TO_FRAG_LOG2 = 3;
	localparam int INODE_SHIFT      = 7;   // 128-byte inode slot
	localparam int DIV_STAGES       = 32;

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_ZERO_DIV = 2'd1,
		STATUS_OVERFLOW = 2'd2
	} status_t;

	typedef enum logic [IDX_W-1:0] {
		REG_INODES_PER_GROUP    = 4'd0,
		REG_FRAGS_PER_GROUP     = 4'd1,
		REG_INODES_PER_FS_BLOCK = 4'd2,
		REG_GROUP_ROTATION_STEP = 4'd3,
		REG_GROUP_CYCLE_MASK    = 4'd4,
		REG_INODE_AREA_OFFSET   = 4'd5,
		REG_FRAGMENT_BYTES      = 4'd6,
		REG_SLICE_BASE_BYTES    = 4'd7
	} reg_idx_t;

	localparam logic [WORD_W-1:0] FRAG_BYTES_RESET = 32'd1024;

	// Divider result as it leaves the last stage
	typedef struct packed {
		logic              valid;
		logic [WORD_W-1:0] quot;
		logic [WORD_W-1:0] rem;
		logic [WORD_W-1:0] tag;
	} div_res_t;
endpackage
`default_nettype wire

// ----- hdl/ibac_ifs.sv -----
// Handshake channels of the inode byte address calculator.
// Depends on ibac_pkg.
`default_nettype none
interface ibac_req_if;
	logic                      valid;
	logic                      ready;
	logic [ibac_pkg::WORD_W-1:0] inode_number;
	modport source (output valid, output inode_number, input ready);
	modport sink (input valid, input inode_number, output ready);
endinterface

interface ibac_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [ibac_pkg::OFS_W-1:0] byte_offset;
	logic [1:0]                 status;
	modport source (output valid, output byte_offset, output status, input ready);
	modport sink (input valid, input byte_offset, input status, output ready);
endinterface

interface ibac_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [ibac_pkg::IDX_W-1:0] index;
	logic [ibac_pkg::OFS_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ----- hdl/ibac_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, 32 stages.
// Depends on ibac_pkg. The divisor must stay stable while items are in flight.
`default_nettype none
module ibac_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        en,
	input  wire logic                        in_valid,
	input  wire logic [ibac_pkg::WORD_W-1:0] num,
	input  wire logic [ibac_pkg::WORD_W-1:0] den,
	input  wire logic [ibac_pkg::WORD_W-1:0] tag_in,
	output ibac_pkg::div_res_t               res
);
	localparam int W = ibac_pkg::WORD_W;
	localparam int N = ibac_pkg::DIV_STAGES;

	// acc holds {partial remainder, dividend bits left / quotient bits in}
	logic [2*W-1:0] acc_s [0:N-1];
	logic [W-1:0]   tag_s [0:N-1];
	logic [N-1:0]   vld_s;

	genvar i;
	generate
		for (i = 0; i < N; i++) begin : g_stage
			logic [2*W-1:0] acc_in;
			logic [W-1:0]   tag_in_i;
			logic           vld_in;
			logic [W:0]     part;
			logic [W+1:0]   diff;
			logic           ge;

			if (i == 0) begin : g_first
				assign acc_in   = {{W{1'b0}}, num};
				assign tag_in_i = tag_in;
				assign vld_in   = in_valid;
			end else begin : g_next
				assign acc_in   = acc_s[i-1];
				assign tag_in_i = tag_s[i-1];
				assign vld_in   = vld_s[i-1];
			end

			// Shift in the next dividend bit and try the subtract
			assign part = {acc_in[2*W-1:W], acc_in[W-1]};
			assign diff = {1'b0, part} - {2'b00, den};
			assign ge   = ~diff[W+1];

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[i] <= 1'b0;
				end else if (en) begin
					vld_s[i] <= vld_in;
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					acc_s[i] <= {(ge ? diff[W-1:0] : part[W-1:0]), acc_in[W-2:0], ge};
					tag_s[i] <= tag_in_i;
				end
			end
		end
	endgenerate

	assign res.valid = vld_s[N-1];
	assign res.rem   = acc_s[N-1][2*W-1:W];
	assign res.quot  = acc_s[N-1][W-1:0];
	assign res.tag   = tag_s[N-1];
endmodule
`default_nettype wire

// ----- hdl/inode_byte_address_calc_top.sv -----
// Inode byte address calculator: top level with configuration registers.
// Depends on ibac_pkg, ibac_ifs, ibac_div and the defines header.
//
// Returns the byte offset of an inode record on a fast-file-system image.
// One inode number is taken per clock while the response side is not stalling;
// each result passes through 68 register stages (two 32-stage
// dividers, group then block within group, followed by four arithmetic stages),
// the last of which is the output register. A stall on the response side
// freezes the whole pipeline. Configuration writes are taken every cycle and
// must only happen while no request is in flight.
`default_nettype none
`include "inode_byte_address_calc_top_defines.svh"
module inode_byte_address_calc_top (
	input  wire logic   clk,
	input  wire logic   arst_n,
	ibac_req_if.sink    req,
	ibac_rsp_if.source  rsp,
	ibac_cfg_if.sink    cfg
);
	localparam int W = ibac_pkg::WORD_W;
	localparam int O = ibac_pkg::OFS_W;

	logic [W-1:0] ipg_q, fpg_q, ipfb_q, rot_q, mask_q, iao_q, fb_q;
	logic [O-1:0] slice_q;

	// Configuration registers
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ipg_q   <= '0;
			fpg_q   <= '0;
			ipfb_q  <= '0;
			rot_q   <= '0;
			mask_q  <= '0;
			iao_q   <= '0;
			fb_q    <= ibac_pkg::FRAG_BYTES_RESET;
			slice_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				ibac_pkg::REG_INODES_PER_GROUP:    ipg_q   <= cfg.data[W-1:0];
				ibac_pkg::REG_FRAGS_PER_GROUP:     fpg_q   <= cfg.data[W-1:0];
				ibac_pkg::REG_INODES_PER_FS_BLOCK: ipfb_q  <= cfg.data[W-1:0];
				ibac_pkg::REG_GROUP_ROTATION_STEP: rot_q   <= cfg.data[W-1:0];
				ibac_pkg::REG_GROUP_CYCLE_MASK:    mask_q  <= cfg.data[W-1:0];
				ibac_pkg::REG_INODE_AREA_OFFSET:   iao_q   <= cfg.data[W-1:0];
				ibac_pkg::REG_FRAGMENT_BYTES:      fb_q    <= cfg.data[W-1:0];
				ibac_pkg::REG_SLICE_BASE_BYTES:    slice_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// Global advance: move when the output register is free or being drained
	logic adv;
	assign adv       = !rsp.valid || rsp.ready;
	assign req.ready = adv;

	ibac_pkg::div_res_t grp_res, blk_res;

	// Group number and index within group
	ibac_div u_div_group (
		.clk(clk), .arst_n(arst_n), .en(adv),
		.in_valid(req.valid), .num(req.inode_number), .den(ipg_q),
		.tag_in('0), .res(grp_res)
	);

	// Block within group and slot within block; group rides as tag
	ibac_div u_div_block (
		.clk(clk), .arst_n(arst_n), .en(adv),
		.in_valid(grp_res.valid), .num(grp_res.rem), .den(ipfb_q),
		.tag_in(grp_res.quot), .res(blk_res)
	);

	// Stage 1: group products
	logic [2*W-1:0] base_s1, rot_s1;
	logic [W-1:0]   blk_s1, slot_s1;
	logic           vld_s1;

	// Stage 2: fragment address
	logic [2*W+1:0] sum_c;
	logic [O-1:0]   addr_s2;
	logic           big_s2;
	logic [W-1:0]   slot_s2;
	logic           vld_s2;

	// Stage 3: split scaling products
	logic [2*W-1:0] lo_s3;
	logic [2*W-2:0] hi_s3;
	logic           ovf_s3;
	logic [W-1:0]   slot_s3;
	logic           vld_s3;

	// Stage 4: final byte offset
	logic [3*W-1:0] total_c;
	logic           zero_div;
	logic [O-1:0]   ofs_q;
	ibac_pkg::status_t status_q;
	logic           vld_q;

	assign sum_c = {2'b00, base_s1} + {2'b00, rot_s1} + {{(W+2){1'b0}}, iao_q}
		+ {{(W-1){1'b0}}, blk_s1, {ibac_pkg::BLK_TO_FRAG_LOG2{1'b0}}};

	assign total_c = {1'b0, hi_s3, {W{1'b0}}} + {{W{1'b0}}, lo_s3}
		+ {{(3*W-O){1'b0}}, slice_q}
		+ {{(2*W-ibac_pkg::INODE_SHIFT){1'b0}}, slot_s3, {ibac_pkg::INODE_SHIFT{1'b0}}};

	assign zero_div = (ipg_q == '0) || (fpg_q == '0) || (ipfb_q == '0);

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_q  <= 1'b0;
		end else if (adv) begin
			vld_s1 <= blk_res.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_q  <= vld_s3;
		end
	end

	// Advance payload
	always_ff @(posedge clk) begin
		if (adv) begin
			base_s1 <= {{W{1'b0}}, fpg_q} * {{W{1'b0}}, blk_res.tag};
			rot_s1  <= {{W{1'b0}}, rot_q} * {{W{1'b0}}, (blk_res.tag & ~mask_q)};
			blk_s1  <= blk_res.quot;
			slot_s1 <= blk_res.rem;

			addr_s2 <= sum_c[O-1:0];
			big_s2  <= |sum_c[2*W+1:O];
			slot_s2 <= slot_s1;

			lo_s3   <= {{W{1'b0}}, addr_s2[W-1:0]} * {{W{1'b0}}, fb_q};
			hi_s3   <= {{W{1'b0}}, addr_s2[O-1:W]} * {{(O-W){1'b0}}, fb_q};
			ovf_s3  <= big_s2 && (fb_q != '0);
			slot_s3 <= slot_s2;

			if (zero_div) begin
				ofs_q    <= '0;
				status_q <= ibac_pkg::STATUS_ZERO_DIV;
			end else if (ovf_s3 || (|total_c[3*W-1:O])) begin
				ofs_q    <= '0;
				status_q <= ibac_pkg::STATUS_OVERFLOW;
			end else begin
				ofs_q    <= total_c[O-1:0];
				status_q <= ibac_pkg::STATUS_OK;
			end
		end
	end

	assign rsp.valid       = vld_q;
	assign rsp.byte_offset = ofs_q;
	assign rsp.status      = status_q;

	`IBAC_ASSERT(a_err_zero_ofs, clk, arst_n, (rsp.valid && rsp.status != ibac_pkg::STATUS_OK) |-> (rsp.byte_offset == '0), "error response carries nonzero offset")
	`IBAC_ASSERT(a_zero_div_cfg, clk, arst_n, (rsp.valid && rsp.status == ibac_pkg::STATUS_ZERO_DIV) |-> zero_div, "zero divisor status with valid geometry")
	`IBAC_ASSERT_NEVER(a_ovf_geom, clk, arst_n, rsp.valid && rsp.status == ibac_pkg::STATUS_OVERFLOW && zero_div, "overflow status with zero geometry")
endmodule
`default_nettype wire

// ----- sim/inode_byte_address_calc_top_tb.sv -----
// Self-checking testbench for the inode byte address calculator.
// Depends on ibac_pkg, ibac_ifs and the inode_byte_address_calc_top RTL.
`timescale 1ns / 1ps

module inode_byte_address_calc_top_tb;

	typedef struct {
		logic [ibac_pkg::OFS_W-1:0] ofs;
		ibac_pkg::status_t          st;
	} inode_loc_t;

	// Holds the register image and the queue of expected inode locations
	class inode_loc_board;
		logic [31:0] ipg, fpg, ipb, rot, cmask, area, fbytes;
		logic [62:0] slice;
		inode_loc_t  pending[$];
		int          errors;

		function new();
			ipg = 0; fpg = 0; ipb = 0; rot = 0; cmask = 0; area = 0;
			fbytes = ibac_pkg::FRAG_BYTES_RESET; slice = 0; errors = 0;
		endfunction

		function void write_reg(ibac_pkg::reg_idx_t idx, logic [62:0] d);
			case (idx)
				ibac_pkg::REG_INODES_PER_GROUP: ipg = d[31:0];
				ibac_pkg::REG_FRAGS_PER_GROUP: fpg = d[31:0];
				ibac_pkg::REG_INODES_PER_FS_BLOCK: ipb = d[31:0];
				ibac_pkg::REG_GROUP_ROTATION_STEP: rot = d[31:0];
				ibac_pkg::REG_GROUP_CYCLE_MASK: cmask = d[31:0];
				ibac_pkg::REG_INODE_AREA_OFFSET: area = d[31:0];
				ibac_pkg::REG_FRAGMENT_BYTES: fbytes = d[31:0];
				ibac_pkg::REG_SLICE_BASE_BYTES: slice = d;
				default: ;
			endcase
		endfunction

		// Exact arithmetic in 160 bits; nothing here can wrap
		function void note_request(logic [31:0] ino);
			logic [159:0] grp, idx_in_grp, blk, slot, addr, total;
			inode_loc_t e;
			if (ipg == 0 || fpg == 0 || ipb == 0) begin
				e.ofs = 0; e.st = ibac_pkg::STATUS_ZERO_DIV;
			end else begin
				grp = ino / ipg;
				idx_in_grp = ino % ipg;
				blk = idx_in_grp / ipb;
				slot = idx_in_grp % ipb;
				addr = 160'(fpg) * grp + 160'(rot) * (grp & 160'(~cmask)) + 160'(area)
					+ (blk << ibac_pkg::BLK_TO_FRAG_LOG2);
				total = addr * 160'(fbytes) + 160'(slice) + (slot << ibac_pkg::INODE_SHIFT);
				if (total > 160'h7FFF_FFFF_FFFF_FFFF) begin
					e.ofs = 0; e.st = ibac_pkg::STATUS_OVERFLOW;
				end else begin
					e.ofs = total[62:0]; e.st = ibac_pkg::STATUS_OK;
				end
			end
			pending.push_back(e);
		endfunction

		function void check_response(logic [62:0] ofs, logic [1:0] st);
			inode_loc_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected response ofs=%0h status=%0d", $time, ofs, st);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (st !== e.st) begin
				$display("%0t: status expected %0d actual %0d", $time, e.st, st);
				errors++;
			end
			if (ofs !== e.ofs) begin
				$display("%0t: byte_offset expected %0h actual %0h", $time, e.ofs, ofs);
				errors++;
			end
		endfunction
	endclass

	localparam int LATENCY = 68;
	localparam int N_RANDOM = 1030;

	logic clk = 0;
	logic arst_n = 0;
	ibac_req_if req();
	ibac_rsp_if rsp();
	ibac_cfg_if cfg();

	inode_loc_board board = new();
	int  cycles = 0;
	int  hold_off = 0;
	int  rsp_wait = 0;
	int  responses = 0;
	bit  allow_stall = 0;

	inode_byte_address_calc_top u_top (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.source), .cfg(cfg.sink)
	);

	always #6 clk = ~clk;

	initial begin
		req.valid = 0; req.inode_number = 0;
		cfg.valid = 0; cfg.index = 0; cfg.data = 0;
		rsp.ready = 0;
	end

	// Count cycles and bail out on a hang
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Check each accepted response
	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready) begin
			board.check_response(rsp.byte_offset, rsp.status);
			responses <= responses + 1;
		end
	end

	// Drive ready: draw a random wait per response, plus one long hold-off
	always @(posedge clk) begin
		int wait_n;
		if (!arst_n) begin
			rsp.ready <= 0;
			rsp_wait <= 0;
		end else if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			rsp.ready <= 0;
		end else if (rsp_wait > 0) begin
			rsp_wait <= rsp_wait - 1;
			rsp.ready <= (rsp_wait == 1);
		end else if (allow_stall && rsp.valid && rsp.ready) begin
			wait_n = $urandom_range(0, 5);
			rsp_wait <= wait_n;
			rsp.ready <= (wait_n == 0);
		end else begin
			rsp.ready <= 1;
		end
	end

	task automatic write_cfg(ibac_pkg::reg_idx_t idx, logic [62:0] d);
		cfg.valid <= 1; cfg.index <= idx; cfg.data <= d;
		do @(posedge clk); while (!cfg.ready);
		board.write_reg(idx, d);
		cfg.valid <= 0;
	endtask

	task automatic send_inode(logic [31:0] ino, bit gaps);
		int gap;
		gap = gaps ? $urandom_range(0, 5) : 0;
		if (gap > 0) begin
			req.valid <= 0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1; req.inode_number <= ino;
		do @(posedge clk); while (!req.ready);
		board.note_request(ino);
	endtask

	task automatic drain();
		req.valid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic load_geometry(logic [31:0] a, b, c, d, e, f, g, logic [62:0] s);
		write_cfg(ibac_pkg::REG_INODES_PER_GROUP, a);
		write_cfg(ibac_pkg::REG_FRAGS_PER_GROUP, b);
		write_cfg(ibac_pkg::REG_INODES_PER_FS_BLOCK, c);
		write_cfg(ibac_pkg::REG_GROUP_ROTATION_STEP, d);
		write_cfg(ibac_pkg::REG_GROUP_CYCLE_MASK, e);
		write_cfg(ibac_pkg::REG_INODE_AREA_OFFSET, f);
		write_cfg(ibac_pkg::REG_FRAGMENT_BYTES, g);
		write_cfg(ibac_pkg::REG_SLICE_BASE_BYTES, s);
	endtask

	function automatic logic [31:0] pick_inode(logic [31:0] ipg);
		case ($urandom_range(0, 3))
			0: return $urandom();
			1: return $urandom_range(0, 4095);
			2: return (ipg == 0) ? $urandom() : ipg * $urandom_range(0, 64) - $urandom_range(0, 1);
			default: return 32'hFFFF_FFFF - $urandom_range(0, 255);
		endcase
	endfunction

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		allow_stall = 1;

		// Directed: reset geometry gives the zero divisor status
		send_inode(0, 0);
		send_inode(32'hFFFF_FFFF, 0);
		drain();
		// Typical layout, ends of the inode range
		load_geometry(2048, 8192, 64, 0, 0, 256, 2048, 0);
		send_inode(0, 0); send_inode(1, 0); send_inode(63, 0); send_inode(64, 0);
		send_inode(2047, 0); send_inode(2048, 0); send_inode(32'hFFFF_FFFF, 0);
		drain();
		// Rotation active, zero fragment size, big slice base
		load_geometry(1, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 0,
			63'h7FFF_FFFF_FFFF_FFFF);
		send_inode(0, 0); send_inode(32'hFFFF_FFFF, 0); send_inode(32'h5555_5555, 0);
		drain();
		// Overflow via huge fragment size, and one zero divisor at a time
		write_cfg(ibac_pkg::REG_FRAGMENT_BYTES, 32'hFFFF_FFFF);
		write_cfg(ibac_pkg::REG_SLICE_BASE_BYTES, 0);
		send_inode(32'hFFFF_FFFF, 0); send_inode(0, 0); send_inode(32'hAAAA_AAAA, 0);
		drain();
		write_cfg(ibac_pkg::REG_INODES_PER_FS_BLOCK, 0);
		send_inode(5, 0);
		drain();
		write_cfg(ibac_pkg::REG_INODES_PER_FS_BLOCK, 3);
		write_cfg(ibac_pkg::REG_FRAGS_PER_GROUP, 0);
		send_inode(7, 0);
		drain();

		// Random phases with fresh geometry; long output hold-off in the first
		for (int ph = 0; ph < 10; ph++) begin
			load_geometry(
				($urandom_range(0, 19) == 0) ? 0 : (ph[0] ? $urandom() : $urandom_range(1, 5000)),
				($urandom_range(0, 19) == 0) ? 0 : (ph[1] ? $urandom() : $urandom_range(1, 50000)),
				($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 300),
				ph[2] ? $urandom() : $urandom_range(0, 100),
				$urandom(),
				$urandom(),
				ph[1] ? $urandom() : (32'd512 << $urandom_range(0, 6)),
				(ph == 9) ? 63'h7FFF_FFFF_FFFF_FFF0 : {$urandom(), $urandom()} >> $urandom_range(1, 63));
			if (ph == 0) hold_off <= 300;
			for (int k = 0; k < N_RANDOM / 10; k++)
				send_inode(pick_inode(board.ipg), (ph != 3));
			drain();
		end

		$display("Ran %0d requests over directed and ten random geometries, incl. zero divisor,",
			responses);
		$display("overflow, rotation, zero fragment size and a long output stall.");
		if (board.errors == 0 && board.pending.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
